/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every sampled edge.
`define CHK_HOLDS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Antecedent at one edge requires the consequent at the next edge.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/iexp_pkg.sv */
`timescale 1ns / 1ps
package iexp_pkg;

   typedef enum logic [2:0] {
      OPC_ADD    = 3'd0,
      OPC_SUB    = 3'd1,
      OPC_MUL    = 3'd2,
      OPC_DIV    = 3'd3,
      OPC_LPAREN = 3'd4
   } op_code_type;

   typedef enum logic [2:0] {
      TK_DIGIT,
      TK_LPAR,
      TK_RPAR,
      TK_OP,
      TK_BAD
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   digit;
      op_code_type  opc;
      logic         last;
   } token_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENDNUM,
      S_LOOP,
      S_OPFILL,
      S_APPLY_RD,
      S_APPLY_EX,
      S_DIV_WAIT,
      S_PUSHOP,
      S_FINISH,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      M_LPAR,
      M_RPAR,
      M_OP,
      M_FLUSH
   } mode_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DIVZERO   = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_MALFORMED = 3'd3;
   localparam logic [2:0] ST_BADCHAR   = 3'd4;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   function automatic logic is_hi_prec(input op_code_type op);
      return (op == OPC_MUL) || (op == OPC_DIV);
   endfunction

endpackage

/* rtl/core/iexp_ram.sv */
`timescale 1ns / 1ps
module iexp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/iexp_div.sv */
`timescale 1ns / 1ps
module iexp_div import iexp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output div_rsp_type rsp
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

/* rtl/core/iexp_fifo.sv */
`timescale 1ns / 1ps
module iexp_fifo import iexp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_tok,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_tok
);

   token_type  slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_tok;
      end
   end

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_tok   = slot_ff[rptr_ff];

endmodule

/* rtl/core/iexp_front.sv */
`timescale 1ns / 1ps
module iexp_front import iexp_pkg::*; (
   input  logic       req_valid,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       req_stall,
   input  logic       q_full,
   output logic       q_push,
   output token_type  q_tok
);

   logic [7:0] dig;

   // Sort the character into a token kind.
   always_comb begin
      dig         = req_ch - CH_ZERO;
      q_tok.kind  = TK_BAD;
      q_tok.digit = dig[3:0];
      q_tok.opc   = OPC_ADD;
      q_tok.last  = req_last;
      if (req_ch >= CH_ZERO && req_ch <= CH_NINE) begin
         q_tok.kind = TK_DIGIT;
      end else begin
         case (req_ch)
            CH_LPAR:  q_tok.kind = TK_LPAR;
            CH_RPAR:  q_tok.kind = TK_RPAR;
            CH_PLUS:  begin q_tok.kind = TK_OP; q_tok.opc = OPC_ADD; end
            CH_MINUS: begin q_tok.kind = TK_OP; q_tok.opc = OPC_SUB; end
            CH_STAR:  begin q_tok.kind = TK_OP; q_tok.opc = OPC_MUL; end
            CH_SLASH: begin q_tok.kind = TK_OP; q_tok.opc = OPC_DIV; end
            default:  q_tok.kind = TK_BAD;
         endcase
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

/* rtl/core/iexp_back.sv */
`timescale 1ns / 1ps
module iexp_back import iexp_pkg::*; #(
   parameter int OP_DEPTH  = 16,
   parameter int VAL_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        tok_valid,
   input  token_type   tok,
   output logic        tok_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_status
);

   localparam int OCW = $clog2(OP_DEPTH + 1);
   localparam int OAW = $clog2(OP_DEPTH);
   localparam int VCW = $clog2(VAL_DEPTH + 1);
   localparam int VAW = $clog2(VAL_DEPTH);

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   op_code_type code_ff, code_in;
   op_code_type cur_ff, cur_in;
   op_code_type otos_ff, otos_in;
   logic        last_ff, last_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] acc_ff, acc_in;
   logic        innum_ff, innum_in;
   logic [OCW-1:0] oc_ff, oc_in;
   logic [VCW-1:0] vc_ff, vc_in;
   logic [31:0] vtos_ff, vtos_in;
   logic        qneg_ff, qneg_in;
   logic        rv_ff, rv_in;
   logic [31:0] rval_ff, rval_in;
   logic [2:0]  rst_ff, rst_in;

   logic           o_we, v_we;
   logic [OAW-1:0] o_waddr, o_raddr;
   logic [VAW-1:0] v_waddr, v_raddr;
   logic [2:0]     o_rdata;
   logic [31:0]    v_rdata;
   logic [31:0]    acc_x10, lhs, rhs, prod, lhs_mag, rhs_mag;
   logic           oc_zero, vc_lt2, o_full, v_full, stop_op, can_emit, div_start;
   div_rsp_type    div_rsp;

   assign oc_zero  = (oc_ff == '0);
   assign vc_lt2   = (vc_ff < VCW'(2));
   assign o_full   = (oc_ff == OCW'(OP_DEPTH));
   assign v_full   = (vc_ff == VCW'(VAL_DEPTH));
   assign stop_op  = oc_zero || (otos_ff == OPC_LPAREN) ||
                     (!is_hi_prec(otos_ff) && is_hi_prec(code_ff));
   assign can_emit = !rv_ff || !rsp_stall;
   assign o_waddr  = OAW'(oc_ff - OCW'(1));
   assign o_raddr  = OAW'(oc_ff - OCW'(2));
   assign v_waddr  = VAW'(vc_ff - VCW'(1));
   assign v_raddr  = VAW'(vc_ff - VCW'(2));
   assign acc_x10  = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + {28'd0, tok.digit};
   assign lhs      = v_rdata;
   assign rhs      = vtos_ff;
   assign prod     = lhs * rhs;
   assign lhs_mag  = lhs[31] ? (32'd0 - lhs) : lhs;
   assign rhs_mag  = rhs[31] ? (32'd0 - rhs) : rhs;
   assign tok_pop  = (state_ff == S_IDLE) && tok_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (tok_valid) begin
               if (err_ff == ST_OK && (tok.kind == TK_LPAR || tok.kind == TK_RPAR ||
                   tok.kind == TK_OP)) begin
                  state_in = S_ENDNUM;
               end else if (tok.last) begin
                  state_in = S_ENDNUM;
               end
            end
         end
         S_ENDNUM:   state_in = (mode_ff == M_LPAR) ? S_PUSHOP : S_LOOP;
         S_LOOP: begin
            if (err_ff != ST_OK) begin
               state_in = (mode_ff == M_FLUSH) ? S_EMIT : S_FINISH;
            end else begin
               case (mode_ff)
                  M_RPAR:  state_in = oc_zero ? S_FINISH : S_OPFILL;
                  M_OP:    state_in = stop_op ? S_PUSHOP : S_OPFILL;
                  M_FLUSH: state_in = (oc_zero || otos_ff == OPC_LPAREN) ? S_EMIT : S_OPFILL;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_OPFILL:   state_in = (cur_ff == OPC_LPAREN) ? S_FINISH : S_APPLY_RD;
         S_APPLY_RD: state_in = vc_lt2 ? S_LOOP : S_APPLY_EX;
         S_APPLY_EX: begin
            if (cur_ff == OPC_DIV && rhs != 32'd0) begin
               state_in = S_DIV_WAIT;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_DIV_WAIT: state_in = div_rsp.done ? S_LOOP : S_DIV_WAIT;
         S_PUSHOP:   state_in = S_FINISH;
         S_FINISH:   state_in = last_ff ? S_ENDNUM : S_IDLE;
         S_EMIT:     state_in = can_emit ? S_IDLE : S_EMIT;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and stack control
   always_comb begin
      mode_in   = mode_ff;
      code_in   = code_ff;
      cur_in    = cur_ff;
      otos_in   = otos_ff;
      last_in   = last_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      innum_in  = innum_ff;
      oc_in     = oc_ff;
      vc_in     = vc_ff;
      vtos_in   = vtos_ff;
      qneg_in   = qneg_ff;
      rv_in     = rv_ff && rsp_stall;
      rval_in   = rval_ff;
      rst_in    = rst_ff;
      o_we      = 1'b0;
      v_we      = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (tok_valid) begin
               last_in = tok.last;
               if (err_ff == ST_OK) begin
                  case (tok.kind)
                     TK_DIGIT: begin
                        acc_in   = innum_ff ? acc_x10 : {28'd0, tok.digit};
                        innum_in = 1'b1;
                     end
                     TK_LPAR: begin mode_in = M_LPAR; code_in = OPC_LPAREN; end
                     TK_RPAR: mode_in = M_RPAR;
                     TK_OP:   begin mode_in = M_OP; code_in = tok.opc; end
                     default: err_in = ST_BADCHAR;
                  endcase
               end
               if (err_ff != ST_OK || tok.kind == TK_DIGIT || tok.kind == TK_BAD) begin
                  mode_in = M_FLUSH;
               end
            end
         end
         S_ENDNUM: begin
            if (err_ff == ST_OK && innum_ff) begin
               if (v_full) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  v_we    = (vc_ff != '0);
                  vtos_in = acc_ff;
                  vc_in   = vc_ff + VCW'(1);
               end
               innum_in = 1'b0;
               acc_in   = '0;
            end
         end
         S_LOOP: begin
            if (err_ff == ST_OK) begin
               case (mode_ff)
                  M_RPAR: begin
                     if (oc_zero) begin
                        err_in = ST_MALFORMED;
                     end else begin
                        cur_in = otos_ff;
                        oc_in  = oc_ff - OCW'(1);
                     end
                  end
                  M_OP: begin
                     if (!stop_op) begin
                        cur_in = otos_ff;
                        oc_in  = oc_ff - OCW'(1);
                     end
                  end
                  M_FLUSH: begin
                     if (oc_zero) begin
                        if (vc_ff != VCW'(1)) begin
                           err_in = ST_MALFORMED;
                        end
                     end else if (otos_ff == OPC_LPAREN) begin
                        err_in = ST_MALFORMED;
                     end else begin
                        cur_in = otos_ff;
                        oc_in  = oc_ff - OCW'(1);
                     end
                  end
                  default: err_in = err_ff;
               endcase
            end
         end
         S_OPFILL:   otos_in = op_code_type'(o_rdata);
         S_APPLY_RD: begin
            if (vc_lt2) begin
               err_in = ST_MALFORMED;
            end
         end
         S_APPLY_EX: begin
            case (cur_ff)
               OPC_ADD: begin vtos_in = lhs + rhs; vc_in = vc_ff - VCW'(1); end
               OPC_SUB: begin vtos_in = lhs - rhs; vc_in = vc_ff - VCW'(1); end
               OPC_MUL: begin vtos_in = prod;      vc_in = vc_ff - VCW'(1); end
               default: begin
                  if (rhs == 32'd0) begin
                     err_in = ST_DIVZERO;
                  end else begin
                     div_start = 1'b1;
                     qneg_in   = lhs[31] ^ rhs[31];
                  end
               end
            endcase
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               vtos_in = qneg_ff ? (32'd0 - div_rsp.quot) : div_rsp.quot;
               vc_in   = vc_ff - VCW'(1);
            end
         end
         S_PUSHOP: begin
            if (err_ff == ST_OK) begin
               if (o_full) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  o_we    = !oc_zero;
                  otos_in = code_ff;
                  oc_in   = oc_ff + OCW'(1);
               end
            end
         end
         S_FINISH: mode_in = M_FLUSH;
         S_EMIT: begin
            if (can_emit) begin
               rv_in    = 1'b1;
               rval_in  = (err_ff == ST_OK) ? vtos_ff : 32'd0;
               rst_in   = err_ff;
               err_in   = ST_OK;
               oc_in    = '0;
               vc_in    = '0;
               acc_in   = '0;
               innum_in = 1'b0;
            end
         end
         default: err_in = err_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= ST_OK;
         acc_ff   <= '0;
         innum_ff <= 1'b0;
         oc_ff    <= '0;
         vc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         acc_ff   <= acc_in;
         innum_ff <= innum_in;
         oc_ff    <= oc_in;
         vc_ff    <= vc_in;
         rv_ff    <= rv_in;
      end
      mode_ff <= mode_in;
      code_ff <= code_in;
      cur_ff  <= cur_in;
      otos_ff <= otos_in;
      last_ff <= last_in;
      vtos_ff <= vtos_in;
      qneg_ff <= qneg_in;
      rval_ff <= rval_in;
      rst_ff  <= rst_in;
   end

   iexp_ram #(.WIDTH(3), .DEPTH(OP_DEPTH)) u_op_ram (
      .clock (clock),
      .we    (o_we),
      .waddr (o_waddr),
      .wdata (otos_ff),
      .raddr (o_raddr),
      .rdata (o_rdata)
   );

   iexp_ram #(.WIDTH(32), .DEPTH(VAL_DEPTH)) u_val_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (vtos_ff),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   iexp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lhs_mag),
      .divisor  (rhs_mag),
      .rsp      (div_rsp)
   );

   assign rsp_valid  = rv_ff;
   assign rsp_value  = rval_ff;
   assign rsp_status = rst_ff;

endmodule

/* rtl/core/infix_expression_evaluator_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_valid / req_stall  req_ch[7:0], req_last
// rsp_      out        rsp_valid / rsp_stall  rsp_value[31:0] signed, rsp_status[2:0]
//
// Steps: a digit folds into the accumulator; '(' closes the number and is pushed; ')' or an
// operator closes it and applies stacked operators, '/' via the bit-serial divider. The last
// word closes the number, flushes operators, checks the stacks and loads the result register.
// Reset: synchronous, active high; clears counts, status, accumulator and handshakes.
// Stalls: a two-word queue parts the front from the sequencer, and the result register
// holds a word under rsp_stall while the next expression is already being taken.
module infix_expression_evaluator_top import iexp_pkg::*; #(
   parameter int OP_STACK_DEPTH    = 16,
   parameter int VALUE_STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_ch,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);

   logic        q_push, q_full, q_pop, q_valid;
   token_type   q_in_tok, q_head;
   logic [31:0] value_raw;

   // Front: sort each character into a token and queue it.
   iexp_front u_front (
      .req_valid (req_valid),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_tok     (q_in_tok)
   );

   // Hold up to two tokens so the front keeps taking words while the back works.
   iexp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_tok   (q_in_tok),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_tok   (q_head)
   );

   // Back: operator and value stacks, arithmetic and the result register.
   iexp_back #(
      .OP_DEPTH  (OP_STACK_DEPTH),
      .VAL_DEPTH (VALUE_STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (q_valid),
      .tok        (q_head),
      .tok_pop    (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (value_raw),
      .rsp_status (rsp_status)
   );

   assign rsp_value = $signed(value_raw);

endmodule

/* rtl/core/iexp_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iexp_checker import iexp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_ch,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value,
   input logic [2:0]         rsp_status
);

   `CHK_HOLDS(a_status_range, !rsp_valid || rsp_status <= ST_BADCHAR, "status out of range")
   `CHK_HOLDS(a_err_zero, !rsp_valid || rsp_status == ST_OK || rsp_value == 32'sd0, "bad value")
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_value, rsp_status}), "rsp moved")
   `CHK_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable({req_ch, req_last}), "req moved")

endmodule

bind infix_expression_evaluator_top iexp_checker u_iexp_checker (.*);
